/* rtl/triangle_face_normal_engine_assert.svh */
// assertion macros for the triangle face normal engine
// used by the top level; expects clk and rst in scope
`ifndef TRIANGLE_FACE_NORMAL_ENGINE_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ENGINE_ASSERT_SVH

// same-cycle implication
`define TFN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfn assertion failed");

// next-cycle implication
`define TFN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfn assertion failed");

`endif

/* rtl/tfn_pkg.sv */
// shared types and constants for the triangle face normal engine
// no dependencies
`default_nettype none

package tfn_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;
  localparam int IDX_BITS         = 10;
  localparam int CNT_BITS         = 11;
  localparam int NORM_BITS        = 16;
  localparam int Q_BITS           = 15;
  localparam int V_BITS           = 15;
  localparam int MUL_W            = 33;
  localparam int ACC_W            = 66;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TRI   = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_NREAD,
    S_NCAP,
    S_VREAD,
    S_CROSS,
    S_CHECK,
    S_SHIFT,
    S_SQ,
    S_BIT,
    S_WRITE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic issue;
    logic clr;
    logic sub;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* rtl/triangle_face_normal_engine.sv */
// triangle face normal engine top level: sequencer, vertex and normal stores
// depends on tfn_pkg, tfn_mac and triangle_face_normal_engine_assert.svh
//
// channel   | handshake             | payload
// command   | start / busy          | opcode, vertex_a/b/c, x/y/z_coord
// result    | done (one cycle)      | normal_x/y/z, from_read, degenerate, index_error
// config    | cfg_valid / cfg_ready | cfg_data (vertex_count)
//
// triangles shift the cross product right until it fits the 15-bit root search;
// every product (six cross terms, three squares, two per bit of the root
// search) goes through the one shared multiplier
// after reset the normal store is swept to zero, busy high
// results are a one-cycle beat on done; the receiver cannot stall
`default_nettype none

module triangle_face_normal_engine import tfn_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [IDX_BITS-1:0]         vertex_a,
  input  logic [IDX_BITS-1:0]         vertex_b,
  input  logic [IDX_BITS-1:0]         vertex_c,
  input  logic signed [15:0]          x_coord,
  input  logic signed [15:0]          y_coord,
  input  logic signed [15:0]          z_coord,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CNT_BITS-1:0]         cfg_data,
  output logic                        done,
  output logic signed [NORM_BITS-1:0] normal_x,
  output logic signed [NORM_BITS-1:0] normal_y,
  output logic signed [NORM_BITS-1:0] normal_z,
  output logic                        from_read,
  output logic                        degenerate,
  output logic                        index_error
);

  `include "triangle_face_normal_engine_assert.svh"

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int DW = COORD_BITS + 1;
  localparam int CW = 2 * DW + 1;
  localparam int VW = 3 * COORD_BITS;
  localparam int NW = 3 * NORM_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

  state_t state, state_next;
  logic [3:0]          cnt, cnt_next;
  logic [AW-1:0]       clr_addr;
  logic [CNT_BITS-1:0] vertex_count;

  opcode_t                  op;
  logic [IDX_BITS-1:0]      idx [3];
  logic signed [COORD_BITS-1:0] wx, wy, wz;
  logic signed [COORD_BITS-1:0] vtx [3][3];
  logic [CW-1:0]            mag [3];
  logic                     neg [3];
  logic [29:0]              sq [3];
  logic [31:0]              l2;
  logic [1:0]               comp;
  logic [3:0]               bitpos;
  logic [Q_BITS-1:0]        q;
  logic signed [NORM_BITS-1:0] nrm [3];
  logic                     f_rd, f_deg, f_err;

  logic [VW-1:0] vstore [MAX_VERTICES];
  logic [NW-1:0] nstore [MAX_VERTICES];
  logic [VW-1:0] vrd;
  logic [NW-1:0] nrd;

  logic          vwr_en, vrd_en, nwr_en, nrd_en;
  logic [AW-1:0] vrd_addr, nwr_addr;
  logic [NW-1:0] nwr_data;

  mac_ctrl_t               mctl;
  logic signed [MUL_W-1:0] ma, mb;
  logic signed [ACC_W-1:0] prod, acc;

  logic ok_a, ok_b, ok_c;
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];
  logic signed [CW-1:0] c_cap;
  logic [Q_BITS-1:0]    cand, q_new;
  logic [15:0]          tval;
  logic                 le;
  logic                 big;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  assign ok_a = ({1'b0, idx[0]} < vertex_count) && (int'(idx[0]) < MAX_VERTICES);
  assign ok_b = ({1'b0, idx[1]} < vertex_count) && (int'(idx[1]) < MAX_VERTICES);
  assign ok_c = ({1'b0, idx[2]} < vertex_count) && (int'(idx[2]) < MAX_VERTICES);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = DW'(vtx[1][i]) - DW'(vtx[0][i]);
      e2[i] = DW'(vtx[2][i]) - DW'(vtx[0][i]);
    end
  end

  assign c_cap = acc[CW-1:0];
  assign cand  = q | (Q_BITS'(1) << bitpos);
  assign tval  = {cand, 1'b0} - 16'd1;
  assign le    = $unsigned(prod) <= ACC_W'({sq[comp], 30'd0});
  assign q_new = le ? cand : q;
  assign big   = (mag[0][CW-1:V_BITS] != '0) || (mag[1][CW-1:V_BITS] != '0) ||
                 (mag[2][CW-1:V_BITS] != '0);

  tfn_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mctl),
    .a    (ma),
    .b    (mb),
    .prod (prod),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    mctl       = '0;
    ma         = '0;
    mb         = '0;
    vwr_en     = 1'b0;
    vrd_en     = 1'b0;
    vrd_addr   = AW'(idx[cnt[1:0] == 2'd3 ? 2'd2 : cnt[1:0]]);
    nwr_en     = 1'b0;
    nwr_addr   = AW'(idx[cnt[1:0] == 2'd3 ? 2'd2 : cnt[1:0]]);
    nwr_data   = {nrm[2], nrm[1], nrm[0]};
    nrd_en     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        nwr_en   = 1'b1;
        nwr_addr = clr_addr;
        nwr_data = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cnt_next = '0;
        unique case (op)
          OP_WRITE: begin
            vwr_en     = ok_a;
            state_next = ok_a ? S_IDLE : S_EMIT;
          end
          OP_CLEAR: state_next = S_CLEAR;
          OP_READ:  state_next = ok_a ? S_NREAD : S_EMIT;
          OP_TRI:   state_next = (ok_a && ok_b && ok_c) ? S_VREAD : S_EMIT;
          default:  state_next = S_IDLE;
        endcase
      end
      S_NREAD: begin
        nrd_en     = 1'b1;
        state_next = S_NCAP;
      end
      S_NCAP: state_next = S_EMIT;
      S_VREAD: begin
        vrd_en   = (cnt < 4'd3);
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd3) begin
          cnt_next   = '0;
          state_next = S_CROSS;
        end
      end
      S_CROSS: begin
        mctl.issue = (cnt < 4'd6);
        mctl.clr   = ~cnt[0];
        mctl.sub   = cnt[0];
        unique case (cnt)
          4'd0: begin ma = MUL_W'(e1[1]); mb = MUL_W'(e2[2]); end
          4'd1: begin ma = MUL_W'(e1[2]); mb = MUL_W'(e2[1]); end
          4'd2: begin ma = MUL_W'(e1[2]); mb = MUL_W'(e2[0]); end
          4'd3: begin ma = MUL_W'(e1[0]); mb = MUL_W'(e2[2]); end
          4'd4: begin ma = MUL_W'(e1[0]); mb = MUL_W'(e2[1]); end
          4'd5: begin ma = MUL_W'(e1[1]); mb = MUL_W'(e2[0]); end
          default: begin ma = '0; mb = '0; end
        endcase
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd7) begin
          cnt_next   = '0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (mag[0] == '0 && mag[1] == '0 && mag[2] == '0) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!big) begin
          cnt_next   = '0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        mctl.issue = (cnt < 4'd3);
        mctl.clr   = (cnt == 4'd0);
        ma = MUL_W'(mag[cnt[1:0] == 2'd3 ? 2'd2 : cnt[1:0]][V_BITS-1:0]);
        mb = ma;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd4) begin
          cnt_next   = '0;
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        priority case (cnt)
          4'd0: begin
            mctl.issue = 1'b1;
            ma         = MUL_W'(tval);
            mb         = MUL_W'(tval);
            cnt_next   = 4'd1;
          end
          4'd1: begin
            mctl.issue = 1'b1;
            ma         = MUL_W'(prod[31:0]);
            mb         = MUL_W'(l2);
            cnt_next   = 4'd2;
          end
          default: begin
            cnt_next = '0;
            if (bitpos == 4'd0 && comp == 2'd2) begin
              state_next = S_WRITE;
            end
          end
        endcase
      end
      S_WRITE: begin
        nwr_en   = 1'b1;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd2) begin
          cnt_next   = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      clr_addr     <= '0;
      vertex_count <= '0;
      done         <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= (state == S_EMIT);
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end else begin
        clr_addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vstore[AW'(idx[0])] <= {wz, wy, wx};
    end
    if (vrd_en) begin
      vrd <= vstore[vrd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nwr_en) begin
      nstore[nwr_addr] <= nwr_data;
    end
    if (nrd_en) begin
      nrd <= nstore[AW'(idx[0])];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          op     <= opcode_t'(opcode);
          idx[0] <= vertex_a;
          idx[1] <= vertex_b;
          idx[2] <= vertex_c;
          wx     <= COORD_BITS'(x_coord);
          wy     <= COORD_BITS'(y_coord);
          wz     <= COORD_BITS'(z_coord);
        end
      end
      S_DISPATCH: begin
        f_rd  <= (op == OP_READ);
        f_deg <= 1'b0;
        f_err <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          nrm[i] <= '0;
        end
        if (op == OP_TRI || op == OP_READ) begin
          f_err <= (op == OP_READ) ? !ok_a : !(ok_a && ok_b && ok_c);
        end
      end
      S_NCAP: begin
        nrm[0] <= nrd[NORM_BITS-1:0];
        nrm[1] <= nrd[2*NORM_BITS-1:NORM_BITS];
        nrm[2] <= nrd[NW-1:2*NORM_BITS];
      end
      S_VREAD: begin
        if (cnt != 4'd0) begin
          vtx[cnt[1:0] - 2'd1][0] <= vrd[COORD_BITS-1:0];
          vtx[cnt[1:0] - 2'd1][1] <= vrd[2*COORD_BITS-1:COORD_BITS];
          vtx[cnt[1:0] - 2'd1][2] <= vrd[VW-1:2*COORD_BITS];
        end
      end
      S_CROSS: begin
        if (cnt == 4'd3 || cnt == 4'd5 || cnt == 4'd7) begin
          neg[cnt[2:1] - 2'd1] <= c_cap[CW-1];
          mag[cnt[2:1] - 2'd1] <= c_cap[CW-1] ? CW'(-c_cap) : CW'(c_cap);
        end
      end
      S_CHECK: begin
        f_deg <= (mag[0] == '0 && mag[1] == '0 && mag[2] == '0);
      end
      S_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end
      end
      S_SQ: begin
        if (cnt != 4'd0 && cnt != 4'd4) begin
          sq[cnt[1:0] - 2'd1] <= prod[29:0];
        end
        if (cnt == 4'd4) begin
          l2     <= acc[31:0];
          comp   <= '0;
          bitpos <= 4'(Q_BITS - 1);
          q      <= '0;
        end
      end
      S_BIT: begin
        if (cnt == 4'd2) begin
          if (bitpos == 4'd0) begin
            nrm[comp] <= neg[comp] ? -NORM_BITS'({1'b0, q_new}) : NORM_BITS'({1'b0, q_new});
            comp      <= comp + 2'd1;
            bitpos    <= 4'(Q_BITS - 1);
            q         <= '0;
          end else begin
            q      <= q_new;
            bitpos <= bitpos - 4'd1;
          end
        end
      end
      S_EMIT: begin
        normal_x    <= nrm[0];
        normal_y    <= nrm[1];
        normal_z    <= nrm[2];
        from_read   <= f_rd;
        degenerate  <= f_deg;
        index_error <= f_err;
      end
      default: begin
      end
    endcase
  end

  `TFN_ASSERT_NXT(a_start_takes, start && !busy, busy)
  `TFN_ASSERT_IMP(a_deg_zero, done && degenerate,
                  normal_x == 0 && normal_y == 0 && normal_z == 0)
  `TFN_ASSERT_IMP(a_err_clean, done && index_error,
                  !degenerate && normal_x == 0 && normal_y == 0 && normal_z == 0)
  `TFN_ASSERT_IMP(a_read_not_deg, done && from_read, !degenerate)

endmodule

`default_nettype wire

/* rtl/tfn_mac.sv */
// shared multiply-accumulate unit: registered product, then accumulator
// depends on tfn_pkg
`default_nettype none

module tfn_mac import tfn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctrl_t               ctrl,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  output logic signed [ACC_W-1:0] prod,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [ACC_W-1:0] prod_w;
  logic                    vld1;
  logic                    clr1;
  logic                    sub1;

  assign prod_w = a * b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      clr1 <= 1'b0;
      sub1 <= 1'b0;
    end else begin
      vld1 <= ctrl.issue;
      clr1 <= ctrl.clr;
      sub1 <= ctrl.sub;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod <= prod_w;
    end
    if (vld1) begin
      acc <= (clr1 ? '0 : acc) + (sub1 ? -prod : prod);
    end
  end

endmodule

`default_nettype wire
